### hw/rtl/gbpf_pkg.sv
package gbpf_pkg;

	localparam int DefGridWidth  = 16;
	localparam int DefGridHeight = 16;

	localparam int InUserW  = 2;
	localparam int InDataW  = 16;
	localparam int OutDataW = 24;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	typedef enum logic [3:0] {
		S_CLR_OBS,
		S_IDLE,
		S_CLR_VIS,
		S_INIT,
		S_POP,
		S_POPW,
		S_NCHK,
		S_NWAIT,
		S_TRACE,
		S_TWAIT,
		S_EMIT
	} gbpf_state_t;

endpackage

### hw/rtl/gbpf_ram.sv
module gbpf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/grid_bfs_path_finder.sv
// Breadth-first shortest path on a GRID_HEIGHT x GRID_WIDTH four-connected grid.
// Input transfers carry a command in s_tuser: clear the obstacle map, add one obstacle,
// or search from the first cell to the goal. Clear and add produce nothing; a search
// answers with min(GRID_HEIGHT,16) row transfers (row index, 16-bit path mask,
// found flag), tlast on the final row. After reset and after every clear command
// the obstacle map is swept, one cell per cycle, while s_tready stays low. A
// search first sweeps the visited map, then dequeues cells and checks each
// neighbor in turn; every in-grid neighbor is looked up through one registered
// memory read. The trace back then walks the path cells back to the start, and
// the rows are sent, one per transfer.
module grid_bfs_path_finder #(
	parameter int GRID_WIDTH  = gbpf_pkg::DefGridWidth,
	parameter int GRID_HEIGHT = gbpf_pkg::DefGridHeight
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// command[1:0]
	input  logic [gbpf_pkg::InUserW-1:0]  s_tuser,
	// first_row[3:0], first_col[7:4], goal_row[11:8], goal_col[15:12]
	input  logic [gbpf_pkg::InDataW-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// row_index[3:0], path_mask[19:4], found[20]
	output logic [gbpf_pkg::OutDataW-1:0] m_tdata,
	output logic                          m_tlast
);

	import gbpf_pkg::*;

	localparam int CELLS    = GRID_WIDTH * GRID_HEIGHT;
	localparam int CELL_W   = $clog2(CELLS);
	localparam int ROW_W    = $clog2(GRID_HEIGHT);
	localparam int COL_W    = $clog2(GRID_WIDTH);
	localparam int QW       = ROW_W + COL_W;
	localparam int OUT_ROWS = (GRID_HEIGHT < 16) ? GRID_HEIGHT : 16;
	localparam int PR_W     = (OUT_ROWS > 1) ? $clog2(OUT_ROWS) : 1;

	function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		cell_addr = CELL_W'(r) * CELL_W'(GRID_WIDTH) + CELL_W'(c);
	endfunction

	gbpf_state_t state_q, state_d;

	logic [CELL_W-1:0] cnt_q;
	logic [CELL_W:0]   head_q, tail_q, steps_q;
	logic [ROW_W-1:0]  start_r_q, goal_r_q, cur_r_q, nb_r_q;
	logic [COL_W-1:0]  start_c_q, goal_c_q, cur_c_q, nb_c_q;
	logic [1:0]        dir_q;
	logic              found_q;
	logic [15:0]       path_q [OUT_ROWS];
	logic [PR_W-1:0]   k_q;

	logic [1:0] in_cmd;
	logic [3:0] in_fr, in_fc, in_gr, in_gc;
	logic       in_first_ok, in_goal_ok, s_xfer, m_xfer, cnt_last, k_last;

	assign in_cmd = s_tuser;
	assign in_fr  = s_tdata[3:0];
	assign in_fc  = s_tdata[7:4];
	assign in_gr  = s_tdata[11:8];
	assign in_gc  = s_tdata[15:12];
	assign in_first_ok = (7'(in_fr) < 7'(GRID_HEIGHT)) && (7'(in_fc) < 7'(GRID_WIDTH));
	assign in_goal_ok  = (7'(in_gr) < 7'(GRID_HEIGHT)) && (7'(in_gc) < 7'(GRID_WIDTH));
	assign cnt_last = (cnt_q == CELL_W'(CELLS - 1));
	assign k_last   = (k_q == PR_W'(OUT_ROWS - 1));

	// neighbor of the current cell in direction dir_q
	logic [ROW_W-1:0] nb_r;
	logic [COL_W-1:0] nb_c;
	logic             nb_ok;

	always_comb begin
		nb_r  = cur_r_q;
		nb_c  = cur_c_q;
		nb_ok = 1'b0;
		unique case (dir_q)
			DIR_UP: begin
				nb_r  = cur_r_q - ROW_W'(1);
				nb_ok = (cur_r_q != '0);
			end
			DIR_RIGHT: begin
				nb_c  = cur_c_q + COL_W'(1);
				nb_ok = ((COL_W+1)'(cur_c_q) + (COL_W+1)'(1)) < (COL_W+1)'(GRID_WIDTH);
			end
			DIR_DOWN: begin
				nb_r  = cur_r_q + ROW_W'(1);
				nb_ok = ((ROW_W+1)'(cur_r_q) + (ROW_W+1)'(1)) < (ROW_W+1)'(GRID_HEIGHT);
			end
			default: begin
				nb_c  = cur_c_q - COL_W'(1);
				nb_ok = (cur_c_q != '0);
			end
		endcase
	end

	// memories
	logic              obs_we, obs_wd, obs_rd, vis_we, vis_wd, vis_rd;
	logic [CELL_W-1:0] obs_wa, vis_wa, ov_ra, par_wa, par_ra;
	logic              par_we, q_we;
	logic [1:0]        par_rd;
	logic [CELL_W-1:0] q_wa, q_ra;
	logic [QW-1:0]     q_wd, q_rd;

	gbpf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obs (
		.clk(clk), .we(obs_we), .waddr(obs_wa), .wdata(obs_wd), .raddr(ov_ra), .rdata(obs_rd)
	);
	gbpf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis (
		.clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(ov_ra), .rdata(vis_rd)
	);
	gbpf_ram #(.WIDTH(2), .DEPTH(CELLS)) u_par (
		.clk(clk), .we(par_we), .waddr(par_wa), .wdata(dir_q), .raddr(par_ra), .rdata(par_rd)
	);
	gbpf_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
	);

	logic [ROW_W-1:0] q_r;
	logic [COL_W-1:0] q_c;
	logic             take_nb, at_start, trace_stop;
	logic [ROW_W-1:0] prev_r;
	logic [COL_W-1:0] prev_c;
	logic             prev_ok;

	assign q_r = q_rd[QW-1:COL_W];
	assign q_c = q_rd[COL_W-1:0];
	assign take_nb = !obs_rd && !vis_rd && (tail_q < (CELL_W+1)'(CELLS));
	assign at_start = (cur_r_q == start_r_q) && (cur_c_q == start_c_q);
	assign trace_stop = at_start || (steps_q == (CELL_W+1)'(CELLS));

	// step back along the recorded parent direction
	always_comb begin
		prev_r  = cur_r_q;
		prev_c  = cur_c_q;
		prev_ok = 1'b0;
		unique case (par_rd)
			DIR_UP: begin
				prev_r  = cur_r_q + ROW_W'(1);
				prev_ok = ((ROW_W+1)'(cur_r_q) + (ROW_W+1)'(1)) < (ROW_W+1)'(GRID_HEIGHT);
			end
			DIR_RIGHT: begin
				prev_c  = cur_c_q - COL_W'(1);
				prev_ok = (cur_c_q != '0);
			end
			DIR_DOWN: begin
				prev_r  = cur_r_q - ROW_W'(1);
				prev_ok = (cur_r_q != '0);
			end
			default: begin
				prev_c  = cur_c_q + COL_W'(1);
				prev_ok = ((COL_W+1)'(cur_c_q) + (COL_W+1)'(1)) < (COL_W+1)'(GRID_WIDTH);
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR_OBS: if (cnt_last) state_d = S_IDLE;
			S_IDLE: begin
				if (s_tvalid) begin
					case (in_cmd)
						CMD_CLEAR:  state_d = S_CLR_OBS;
						CMD_SEARCH: state_d = (in_first_ok && in_goal_ok) ? S_CLR_VIS : S_EMIT;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_CLR_VIS: if (cnt_last) state_d = S_INIT;
			S_INIT:    state_d = S_POP;
			S_POP:     state_d = (head_q == tail_q) ? S_EMIT : S_POPW;
			S_POPW:    state_d = (q_r == goal_r_q && q_c == goal_c_q) ? S_TRACE : S_NCHK;
			S_NCHK: begin
				if (nb_ok) state_d = S_NWAIT;
				else if (dir_q == DIR_LEFT) state_d = S_POP;
			end
			S_NWAIT:   state_d = (dir_q == DIR_LEFT) ? S_POP : S_NCHK;
			S_TRACE:   state_d = trace_stop ? S_EMIT : S_TWAIT;
			S_TWAIT:   state_d = prev_ok ? S_TRACE : S_EMIT;
			S_EMIT:    if (m_tready && k_last) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs and memory controls
	logic             set_en;
	logic [ROW_W-1:0] set_r;
	logic [COL_W-1:0] set_c;

	always_comb begin
		s_tready = (state_q == S_IDLE);
		m_tvalid = (state_q == S_EMIT);
		obs_we = 1'b0;
		obs_wd = 1'b0;
		obs_wa = cnt_q;
		vis_we = 1'b0;
		vis_wd = 1'b0;
		vis_wa = cnt_q;
		ov_ra  = cell_addr(nb_r, nb_c);
		par_we = 1'b0;
		par_wa = cell_addr(nb_r_q, nb_c_q);
		par_ra = cell_addr(cur_r_q, cur_c_q);
		q_we   = 1'b0;
		q_wa   = tail_q[CELL_W-1:0];
		q_wd   = {nb_r_q, nb_c_q};
		q_ra   = head_q[CELL_W-1:0];
		set_en = 1'b0;
		set_r  = cur_r_q;
		set_c  = cur_c_q;
		unique case (state_q)
			S_CLR_OBS: obs_we = 1'b1;
			S_IDLE: begin
				if (s_tvalid && in_cmd == CMD_ADD && in_first_ok) begin
					obs_we = 1'b1;
					obs_wd = 1'b1;
					obs_wa = cell_addr(ROW_W'(in_fr), COL_W'(in_fc));
				end
			end
			S_CLR_VIS: vis_we = 1'b1;
			S_INIT: begin
				vis_we = 1'b1;
				vis_wd = 1'b1;
				vis_wa = cell_addr(start_r_q, start_c_q);
				q_we   = 1'b1;
				q_wa   = '0;
				q_wd   = {start_r_q, start_c_q};
			end
			S_NWAIT: begin
				if (take_nb) begin
					vis_we = 1'b1;
					vis_wd = 1'b1;
					vis_wa = cell_addr(nb_r_q, nb_c_q);
					par_we = 1'b1;
					q_we   = 1'b1;
				end
			end
			S_TRACE: begin
				set_en = 1'b1;
				if (trace_stop) begin
					set_r = start_r_q;
					set_c = start_c_q;
				end
			end
			S_TWAIT: begin
				if (!prev_ok) begin
					set_en = 1'b1;
					set_r  = start_r_q;
					set_c  = start_c_q;
				end
			end
			default: ;
		endcase
	end

	assign s_xfer  = s_tvalid && s_tready;
	assign m_xfer  = m_tvalid && m_tready;
	assign m_tdata = {3'b0, found_q, path_q[k_q], 4'(k_q)};
	assign m_tlast = k_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR_OBS;
			cnt_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			steps_q <= '0;
			dir_q   <= DIR_UP;
			found_q <= 1'b0;
			k_q     <= '0;
			for (int i = 0; i < OUT_ROWS; i++) path_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR_OBS || state_q == S_CLR_VIS) begin
				cnt_q <= cnt_last ? '0 : cnt_q + CELL_W'(1);
			end
			if (s_xfer && in_cmd == CMD_SEARCH) begin
				start_r_q <= ROW_W'(in_fr);
				start_c_q <= COL_W'(in_fc);
				goal_r_q  <= ROW_W'(in_gr);
				goal_c_q  <= COL_W'(in_gc);
				found_q   <= 1'b0;
				k_q       <= '0;
				for (int i = 0; i < OUT_ROWS; i++) path_q[i] <= '0;
			end
			if (state_q == S_INIT) begin
				head_q <= '0;
				tail_q <= (CELL_W+1)'(1);
			end
			if (state_q == S_POP && head_q != tail_q) begin
				head_q <= head_q + (CELL_W+1)'(1);
			end
			if (state_q == S_POPW) begin
				cur_r_q <= q_r;
				cur_c_q <= q_c;
				dir_q   <= DIR_UP;
				steps_q <= '0;
				if (q_r == goal_r_q && q_c == goal_c_q) found_q <= 1'b1;
			end
			if (state_q == S_NCHK) begin
				nb_r_q <= nb_r;
				nb_c_q <= nb_c;
				if (!nb_ok) dir_q <= dir_q + 2'd1;
			end
			if (state_q == S_NWAIT) begin
				dir_q <= dir_q + 2'd1;
				if (take_nb) tail_q <= tail_q + (CELL_W+1)'(1);
			end
			if (state_q == S_TWAIT && prev_ok) begin
				cur_r_q <= prev_r;
				cur_c_q <= prev_c;
				steps_q <= steps_q + (CELL_W+1)'(1);
			end
			// only cells inside the reported window leave a mark
			if (set_en && (7'(set_r) < 7'(OUT_ROWS)) && (7'(set_c) < 7'd16)) begin
				path_q[PR_W'(set_r)][4'(set_c)] <= 1'b1;
			end
			if (m_xfer) begin
				k_q <= k_last ? '0 : k_q + PR_W'(1);
			end
		end
	end

endmodule

### hw/rtl/gbpf_checker.sv
module gbpf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [gbpf_pkg::OutDataW-1:0] m_tdata,
	input logic                          m_tlast
);

	// a stalled result transfer holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result payload changed while stalled");

	// no input is taken while rows are being sent
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input accepted during row output");

	// rows follow one another in order with no gap
	a_next_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1)
			&& (m_tdata[20] == $past(m_tdata[20])))
		else $error("row sequence broken");

	// a search answer starts at row zero
	a_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !$past(m_tvalid) |-> m_tdata[3:0] == 4'd0)
		else $error("search answer did not start at row zero");

	// the final row ends the answer
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("rows continued after tlast");

endmodule

bind grid_bfs_path_finder gbpf_checker u_gbpf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);
